@@ rtl/ani_pkg.sv @@
// Shared types, constants and widths for the arpeggiator note index block.
`default_nettype none

package ani_pkg;

  localparam int MaxNotes = 32;
  localparam int CountW   = 6;
  localparam int TickW    = 32;
  localparam int IdxW     = 5;
  localparam int NW       = $clog2(MaxNotes + 1);
  localparam int DivW     = $clog2(2 * MaxNotes - 1);
  localparam int HashSt   = 3;
  localparam int Latency  = HashSt + TickW + 1;

  localparam logic [TickW-1:0] HashSeed = 32'h9E3779B9;
  localparam logic [TickW-1:0] HashMul1 = 32'h85EBCA6B;
  localparam logic [TickW-1:0] HashMul2 = 32'hC2B2AE35;

  typedef enum logic [1:0] {
    DirUp     = 2'd0,
    DirDown   = 2'd1,
    DirUpDown = 2'd2,
    DirRandom = 2'd3
  } dir_e;

  // Per-transaction control carried alongside the datapath.
  typedef struct packed {
    dir_e            dir;
    logic [NW-1:0]   n;
    logic [DivW-1:0] div;
    logic            zero;
  } side_t;

  // One divider cell's worth of state.
  typedef struct packed {
    logic [DivW-1:0]  rem;
    logic [TickW-1:0] dvd;
    side_t            side;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/ani_hash.sv @@
// Three-stage pipelined fmix32 finalizer; selects hashed or raw tick as dividend.
`default_nettype none

module ani_hash (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [ani_pkg::TickW-1:0] tick_i,
  input  ani_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [ani_pkg::TickW-1:0] dvd_o,
  output ani_pkg::side_t            side_o
);
  import ani_pkg::*;

  logic [2:0]       valid_q;
  logic [TickW-1:0] tick_q [3];
  side_t            side_q [3];
  logic [TickW-1:0] h1_q, h2_q, h3_q;
  logic [TickW-1:0] x0, h1_d, h2_d, h3_d, h4;

  assign x0   = tick_i + HashSeed;
  assign h1_d = x0 ^ (x0 >> 16);
  assign h2_d = h1_q * HashMul1;
  assign h3_d = (h2_q ^ (h2_q >> 13)) * HashMul2;
  assign h4   = h3_q ^ (h3_q >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q      <= h1_d;
    h2_q      <= h2_d;
    h3_q      <= h3_d;
    tick_q[0] <= tick_i;
    tick_q[1] <= tick_q[0];
    tick_q[2] <= tick_q[1];
    side_q[0] <= side_i;
    side_q[1] <= side_q[0];
    side_q[2] <= side_q[1];
  end

  assign valid_o = valid_q[2];
  assign side_o  = side_q[2];
  assign dvd_o   = (side_q[2].dir == DirRandom) ? h4 : tick_q[2];

endmodule

`default_nettype wire

@@ rtl/ani_div_cell.sv @@
// One restoring-division cell: takes one dividend bit and reduces the remainder.
`default_nettype none

module ani_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ani_pkg::stage_t stage_i,
  output logic            valid_o,
  output ani_pkg::stage_t stage_o
);
  import ani_pkg::*;

  logic            valid_q;
  stage_t          stage_q, stage_d;
  logic [DivW:0]   trial, diff;
  logic            ge;

  assign trial = {stage_i.rem, stage_i.dvd[TickW-1]};
  assign ge    = trial >= {1'b0, stage_i.side.div};
  assign diff  = trial - {1'b0, stage_i.side.div};

  always_comb begin
    stage_d      = stage_i;
    stage_d.rem  = ge ? diff[DivW-1:0] : trial[DivW-1:0];
    stage_d.dvd  = stage_i.dvd << 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ rtl/arpeggiator_note_index.sv @@
// Top level: arpeggiator note index, hash front end plus a chain of divider cells.
`default_nettype none

// Channel   Ports                               Direction  Handshake
// command   start_i, busy_o, note_count_i, tick_i   in     start_i & !busy_o
// result    done_o, note_index_o                   out     done_o, one cycle
// config    cfg_we_i, cfg_wdata_i                  in      cfg_we_i
//
// One transaction per cycle; busy_o is always low.
// The pipeline has 3 hash stages, 32 divider cells (one dividend bit
// each, tick is 32 bits wide) and one output register.
// Reset clears the valid chain and sets the direction to up.
// The receiver cannot stall; results leave on done_o as they arrive.
// Direction is sampled with each transaction, so later writes do not
// affect transactions in flight.

module arpeggiator_note_index (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [ani_pkg::CountW-1:0] note_count_i,
  input  logic [ani_pkg::TickW-1:0]  tick_i,
  output logic                       done_o,
  output logic [ani_pkg::IdxW-1:0]   note_index_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i
);
  import ani_pkg::*;

  dir_e             dir_q;
  side_t            side_in;
  logic [NW-1:0]    n_sat;
  logic [NW:0]      n_dbl;
  logic [DivW-1:0]  span;

  logic             hash_valid;
  logic [TickW-1:0] hash_dvd;
  side_t            hash_side;

  logic             cell_valid [TickW+1];
  stage_t           cell_stage [TickW+1];

  stage_t           fin;
  logic [DivW:0]    rem_x, n_x, span_x, idx_x;
  logic             done_q;
  logic [IdxW-1:0]  note_index_q;

  assign busy_o = 1'b0;

  // Direction register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirUp;
    end else if (cfg_we_i) begin
      dir_q <= dir_e'(cfg_wdata_i);
    end
  end

  // Saturate the note count and pick the divisor: the count itself, or the
  // ping-pong span for up-down. No notes, or one note in up-down, forces 0.
  always_comb begin
    if (32'(note_count_i) > MaxNotes) begin
      n_sat = NW'(MaxNotes);
    end else begin
      n_sat = NW'(note_count_i);
    end
    n_dbl        = {n_sat, 1'b0};
    span         = DivW'(n_dbl - (NW+1)'(2));
    side_in.dir  = dir_q;
    side_in.n    = n_sat;
    side_in.zero = (n_sat == '0) || ((dir_q == DirUpDown) && (n_sat == NW'(1)));
    if (side_in.zero) begin
      side_in.div = DivW'(1);
    end else if (dir_q == DirUpDown) begin
      side_in.div = span;
    end else begin
      side_in.div = DivW'(n_sat);
    end
  end

  ani_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .tick_i  (tick_i),
    .side_i  (side_in),
    .valid_o (hash_valid),
    .dvd_o   (hash_dvd),
    .side_o  (hash_side)
  );

  assign cell_valid[0]      = hash_valid;
  assign cell_stage[0].rem  = '0;
  assign cell_stage[0].dvd  = hash_dvd;
  assign cell_stage[0].side = hash_side;

  // Remainder chain: cell k consumes dividend bit 31-k.
  for (genvar k = 0; k < TickW; k++) begin : g_cell
    ani_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[k]),
      .stage_i (cell_stage[k]),
      .valid_o (cell_valid[k+1]),
      .stage_o (cell_stage[k+1])
    );
  end

  // Map the remainder to a note index per direction.
  assign fin    = cell_stage[TickW];
  assign rem_x  = (DivW+1)'(fin.rem);
  assign n_x    = (DivW+1)'(fin.side.n);
  assign span_x = (DivW+1)'(fin.side.div);

  always_comb begin
    if (fin.side.zero) begin
      idx_x = '0;
    end else begin
      case (fin.side.dir)
        DirDown:   idx_x = n_x - (DivW+1)'(1) - rem_x;
        DirUpDown: idx_x = (rem_x < n_x) ? rem_x : (span_x - rem_x);
        default:   idx_x = rem_x;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cell_valid[TickW];
    end
  end

  always_ff @(posedge clk_i) begin
    note_index_q <= IdxW'(idx_x);
  end

  assign done_o       = done_q;
  assign note_index_o = note_index_q;

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Latency done_o)
    else $error("result did not appear after fixed latency");

  a_no_orphan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cell_valid[TickW]))
    else $error("result strobe without a transaction at chain end");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[TickW] |-> (fin.rem < fin.side.div))
    else $error("divider remainder not below divisor");

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[TickW] && !fin.side.zero) |-> (idx_x < n_x))
    else $error("note index not below note count");
`endif

endmodule

`default_nettype wire

@@ verif/ani_checker.sv @@
// Checker for the arpeggiator note index: predicts each note index and compares results.
module ani_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [ani_pkg::CountW-1:0] note_count_i,
  input  logic [ani_pkg::TickW-1:0]  tick_i,
  input  logic                       done_i,
  input  logic [ani_pkg::IdxW-1:0]   note_index_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i,
  output int                         pending_o,
  output int                         fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ani_pkg::*;

  typedef struct {
    logic [CountW-1:0] count;
    logic [TickW-1:0]  tick;
    dir_e              dir;
    logic [IdxW-1:0]   index;
  } owed_note_t;

  owed_note_t owed_notes[$];
  dir_e       direction;
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  // Murmur3 32-bit finalizer over the seeded tick.
  function automatic logic [31:0] scramble_tick(logic [31:0] t);
    logic [31:0] h;
    h = t + HashSeed;
    h = h ^ (h >> 16);
    h = h * HashMul1;
    h = h ^ (h >> 13);
    h = h * HashMul2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic logic [IdxW-1:0] note_for_tick(dir_e dir, logic [CountW-1:0] count,
                                                    logic [TickW-1:0] tick);
    logic [31:0] n;
    logic [31:0] span;
    logic [31:0] pos;
    logic [31:0] idx;
    n   = (32'(count) > 32'(MaxNotes)) ? 32'(MaxNotes) : 32'(count);
    idx = '0;
    if (n != 0) begin
      case (dir)
        DirDown: begin
          idx = n - 1 - (tick % n);
        end
        DirUpDown: begin
          if (n == 1) begin
            idx = '0;
          end else begin
            span = 2 * n - 2;
            pos  = tick % span;
            idx  = (pos < n) ? pos : (span - pos);
          end
        end
        DirRandom: begin
          idx = scramble_tick(tick) % n;
        end
        default: begin
          idx = tick % n;
        end
      endcase
    end
    return idx[IdxW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    owed_note_t head;
    owed_note_t fresh;
    if (!rst_ni) begin
      direction = DirUp;
      owed_notes.delete();
    end else begin
      // results first, then the new command, then the register write
      if (done_i) begin
        if (owed_notes.size() == 0) begin
          mismatches++;
          $display("%t unexpected result: expected none, actual note_index %0d",
                   $time, note_index_i);
        end else begin
          head = owed_notes.pop_front();
          if (note_index_i !== head.index) begin
            mismatches++;
            $display("%t note_index mismatch (dir %s count %0d tick %h): expected %0d actual %0d",
                     $time, head.dir.name(), head.count, head.tick, head.index,
                     note_index_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        fresh.count = note_count_i;
        fresh.tick  = tick_i;
        fresh.dir   = direction;
        fresh.index = note_for_tick(direction, note_count_i, tick_i);
        owed_notes.push_back(fresh);
      end
      if (cfg_we_i) begin
        direction = dir_e'(cfg_wdata_i);
      end
    end
    pending_o <= owed_notes.size();
  end

endmodule

@@ verif/testbench.sv @@
// Top of the arpeggiator note index testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ani_pkg::*;

  // no transaction for this many cycles means the block has hung
  localparam int HangLimit  = 2000;
  localparam int SegmentLen = 167;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [CountW-1:0] note_count_i;
  logic [TickW-1:0]  tick_i;
  logic              done_o;
  logic [IdxW-1:0]   note_index_o;
  logic              cfg_we_i;
  logic [1:0]        cfg_wdata_i;

  int pending;
  int fail_count;
  int quiet_cycles = 0;

  arpeggiator_note_index dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .note_count_i (note_count_i),
    .tick_i       (tick_i),
    .done_o       (done_o),
    .note_index_o (note_index_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  ani_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .note_count_i (note_count_i),
    .tick_i       (tick_i),
    .done_i       (done_o),
    .note_index_i (note_index_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hang detector: any accepted command or any result resets the count.
  // The drain pauses before a register write are far shorter than the limit.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HangLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Mostly musical counts (2..32), with empty, single-note and saturating
  // counts mixed in so the special cases keep showing up.
  function automatic logic [CountW-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CountW'(1);
      2:       return CountW'($urandom_range(MaxNotes + 1, 2 ** CountW - 1));
      default: return CountW'($urandom_range(2, MaxNotes));
    endcase
  endfunction

  // Ticks near both ends of the range catch wrap and carry problems in the
  // divider and in the seeded hash; the rest is uniform.
  function automatic logic [TickW-1:0] pick_tick();
    case ($urandom_range(3))
      0:       return TickW'($urandom_range(0, 255));
      1:       return 32'hFFFF_FFFF - TickW'($urandom_range(0, 255));
      default: return TickW'($urandom);
    endcase
  endfunction

  // Offer one command and hold it until accepted. Afterwards each cycle is
  // an idle one (start low, junk on the payload) with the given percentage.
  task automatic request_note(logic [CountW-1:0] count, logic [TickW-1:0] tick, int idle_pct);
    start_i      <= 1'b1;
    note_count_i <= count;
    tick_i       <= tick;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i      <= 1'b0;
      note_count_i <= CountW'($urandom);
      tick_i       <= TickW'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Direction changes only with the pipe empty. Every command yields a
  // result, so an empty expectation queue plus the pipe depth is enough.
  task automatic set_direction(dir_e dir);
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (Latency + 2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dir;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Field extremes: no notes, single note, two notes, full and saturated
  // counts, tick at zero and at all ones.
  task automatic directed_sweep();
    request_note(CountW'(0),  32'hFFFF_FFFF, 0);
    request_note(CountW'(1),  32'hFFFF_FFFF, 0);
    request_note(CountW'(2),  32'hFFFF_FFFF, 0);
    request_note(CountW'(MaxNotes), 32'h0000_0000, 0);
    request_note(CountW'(MaxNotes + 1), 32'h0000_0041, 0);
    request_note(CountW'(2 ** CountW - 1), 32'hFFFF_FFFE, 0);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    note_count_i <= '0;
    tick_i       <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the first sweep runs on the reset direction (up), then
    // each remaining direction is written and swept.
    directed_sweep();
    for (int d = 1; d < 4; d++) begin
      set_direction(dir_e'(d));
      directed_sweep();
    end

    // Random: three sender profiles (light idling, heavy idling, none),
    // each walking through all four directions.
    for (int phase = 0; phase < 3; phase++) begin
      for (int d = 0; d < 4; d++) begin
        set_direction(dir_e'(phase == 1 ? 3 - d : d));
        repeat (SegmentLen) begin
          request_note(pick_count(), pick_tick(),
                       phase == 0 ? 18 : (phase == 1 ? 63 : 0));
        end
      end
    end

    // Drain, then give stray late results a chance to show up.
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (Latency + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
